/* design/assert_macros.svh */
// Assertion macros shared by the header field extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while in reset.
`define PHFE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define PHFE_ASSERT_IMPL(label, clk, rstn, cond, cons, msg) \
    `PHFE_ASSERT(label, clk, rstn, (cond) |-> (cons), msg)

`endif

/* design/phfe_pkg.sv */
// Constants and record type for the packet header field extractor.
package phfe_pkg;

    localparam int unsigned OFF_W = 7;

    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;

    localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
    localparam logic [15:0] POS_IHL        = 16'd14;
    localparam logic [15:0] POS_V4_PROTO   = 16'd23;
    localparam logic [15:0] POS_V6_NEXT    = 16'd20;

    localparam logic [OFF_W-1:0] ETH_HDR_LEN  = 7'd14;
    localparam logic [OFF_W-1:0] IPV6_L4_OFF  = 7'd54;
    localparam logic [OFF_W-1:0] TCP_HDR_LEN  = 7'd20;
    localparam logic [OFF_W-1:0] UDP_HDR_LEN  = 7'd8;

    localparam logic [15:0] IPV4_MIN_LEN   = 16'd34;
    localparam logic [15:0] IPV6_MIN_LEN   = 16'd54;

    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [2:0]  VER_NONE       = 3'd0;
    localparam logic [2:0]  VER_IPV4       = 3'd4;
    localparam logic [2:0]  VER_IPV6       = 3'd6;

    typedef struct packed {
        logic [31:0] iface;
        logic [1:0]  direction;
        logic [15:0] pkt_length;
        logic [2:0]  ip_version;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } phfe_rec_t;

endpackage

/* design/packet_header_field_extractor.sv */
// Top level: input register, header parser and result register.
// A final byte passes through the input register, and its record is then loaded into the result register.
// Throughput: one byte per cycle; a final byte waits only while a record is stalled.
// The input register feeds the parser state update and the record logic combinationally.
// Synchronous active-low reset empties both registers and clears all packet state.
`include "assert_macros.svh"
module packet_header_field_extractor import phfe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pkt_byte,
    input  logic        s_end_of_packet,
    input  logic [1:0]  s_pkt_direction,
    input  logic [31:0] s_iface_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_iface,
    output logic [1:0]  m_out_direction,
    output logic [15:0] m_pkt_length,
    output logic [2:0]  m_ip_version,
    output logic [7:0]  m_ip_protocol,
    output logic [31:0] m_src_addr,
    output logic [31:0] m_dst_addr,
    output logic [15:0] m_src_port,
    output logic [15:0] m_dst_port
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [1:0]  dir_reg;
    logic [31:0] iface_reg;

    logic        advance;
    logic        s_take;
    phfe_rec_t   rec;
    phfe_rec_t   rec_out;

    // a non-final byte never waits; a final one waits for the result register
    assign advance = in_valid_reg && (!last_reg || !m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            byte_reg  <= s_pkt_byte;
            last_reg  <= s_end_of_packet;
            dir_reg   <= s_pkt_direction;
            iface_reg <= s_iface_index;
        end
    end

    phfe_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take_byte     (advance),
        .pkt_byte      (byte_reg),
        .end_of_packet (last_reg),
        .pkt_direction (dir_reg),
        .iface_index   (iface_reg),
        .rec           (rec)
    );

    phfe_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && last_reg),
        .rec_in  (rec),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .rec_out (rec_out)
    );

    assign m_out_iface     = rec_out.iface;
    assign m_out_direction = rec_out.direction;
    assign m_pkt_length    = rec_out.pkt_length;
    assign m_ip_version    = rec_out.ip_version;
    assign m_ip_protocol   = rec_out.ip_protocol;
    assign m_src_addr      = rec_out.src_addr;
    assign m_dst_addr      = rec_out.dst_addr;
    assign m_src_port      = rec_out.src_port;
    assign m_dst_port      = rec_out.dst_port;

    `PHFE_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && last_reg && m_valid && !m_ready, "input stalled without a blocked final byte")
    `PHFE_ASSERT_IMPL(a_version_code, aclk, aresetn, m_valid, m_ip_version == VER_NONE || m_ip_version == VER_IPV4 || m_ip_version == VER_IPV6, "bad IP version in record")
    `PHFE_ASSERT_IMPL(a_ports_need_ip, aclk, aresetn, m_valid && (m_src_port != '0 || m_dst_port != '0), m_ip_version != VER_NONE, "ports reported without an IP header")
    `PHFE_ASSERT_IMPL(a_addr_need_v4, aclk, aresetn, m_valid && (m_src_addr != '0 || m_dst_addr != '0), m_ip_version == VER_IPV4, "addresses reported without IPv4")

endmodule

/* design/phfe_parser.sv */
// Per-packet header state and metadata record logic.
module phfe_parser import phfe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take_byte,
    input  logic [7:0]  pkt_byte,
    input  logic        end_of_packet,
    input  logic [1:0]  pkt_direction,
    input  logic [31:0] iface_index,
    output phfe_rec_t   rec
);

    logic [15:0] count_reg, count_next;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  ihl_reg,   ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] sa_reg,    sa_next;
    logic [31:0] da_reg,    da_next;
    logic [15:0] sp_reg,    sp_next;
    logic [15:0] dp_reg,    dp_next;

    logic             counting;
    logic             in_ip;
    logic             is_v4;
    logic             is_v6;
    logic [OFF_W-1:0] off;
    logic [15:0]      off_ext;
    logic [15:0]      diff;
    logic             have_ip;
    logic             ports_ok;

    always_comb begin
        counting   = count_reg != COUNT_MAX;
        etype_next = etype_reg;
        if (counting && (count_reg == POS_ETYPE_HI || count_reg == POS_ETYPE_LO)) begin
            etype_next = {etype_reg[7:0], pkt_byte};
        end
        is_v4 = etype_next == ETYPE_IPV4;
        is_v6 = etype_next == ETYPE_IPV6;
        in_ip = counting && (count_reg >= 16'(ETH_HDR_LEN));

        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        sa_next    = sa_reg;
        da_next    = da_reg;
        if (in_ip && is_v4) begin
            if (count_reg == POS_IHL) begin
                ihl_next = pkt_byte[3:0];
            end
            if (count_reg == POS_V4_PROTO) begin
                proto_next = pkt_byte;
            end
            if (count_reg inside {[16'd26:16'd29]}) begin
                sa_next = {sa_reg[23:0], pkt_byte};
            end
            if (count_reg inside {[16'd30:16'd33]}) begin
                da_next = {da_reg[23:0], pkt_byte};
            end
        end else if (in_ip && is_v6) begin
            if (count_reg == POS_V6_NEXT) begin
                proto_next = pkt_byte;
            end
        end

        if (is_v4) begin
            off = (ihl_next != 4'd0) ? ETH_HDR_LEN + {1'b0, ihl_next, 2'b00} : '0;
        end else if (is_v6) begin
            off = IPV6_L4_OFF;
        end else begin
            off = '0;
        end
        off_ext = {{(16-OFF_W){1'b0}}, off};
        diff    = count_reg - off_ext;

        sp_next = sp_reg;
        dp_next = dp_reg;
        if (in_ip && off != '0 && count_reg >= off_ext) begin
            if (diff < 16'd2) begin
                sp_next = {sp_reg[7:0], pkt_byte};
            end else if (diff < 16'd4) begin
                dp_next = {dp_reg[7:0], pkt_byte};
            end
        end

        count_next = counting ? count_reg + 16'd1 : count_reg;

        rec.iface       = iface_index;
        rec.direction   = pkt_direction;
        rec.pkt_length  = count_next;
        rec.ip_version  = VER_NONE;
        rec.ip_protocol = '0;
        rec.src_addr    = '0;
        rec.dst_addr    = '0;
        rec.src_port    = '0;
        rec.dst_port    = '0;
        have_ip         = 1'b0;
        if (is_v4 && count_next >= IPV4_MIN_LEN) begin
            rec.ip_version  = VER_IPV4;
            rec.ip_protocol = proto_next;
            rec.src_addr    = sa_next;
            rec.dst_addr    = da_next;
            have_ip         = 1'b1;
        end else if (is_v6 && count_next >= IPV6_MIN_LEN) begin
            rec.ip_version  = VER_IPV6;
            rec.ip_protocol = proto_next;
            have_ip         = 1'b1;
        end
        ports_ok = have_ip && off != '0 &&
            ((proto_next == PROTO_TCP && count_next >= off_ext + 16'(TCP_HDR_LEN)) ||
             (proto_next == PROTO_UDP && count_next >= off_ext + 16'(UDP_HDR_LEN)));
        if (ports_ok) begin
            rec.src_port = sp_next;
            rec.dst_port = dp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take_byte && end_of_packet)) begin
            count_reg <= '0;
            etype_reg <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            sa_reg    <= '0;
            da_reg    <= '0;
            sp_reg    <= '0;
            dp_reg    <= '0;
        end else if (take_byte) begin
            count_reg <= count_next;
            etype_reg <= etype_next;
            ihl_reg   <= ihl_next;
            proto_reg <= proto_next;
            sa_reg    <= sa_next;
            da_reg    <= da_next;
            sp_reg    <= sp_next;
            dp_reg    <= dp_next;
        end
    end

endmodule

/* design/phfe_out_reg.sv */
// Result register holding one metadata record until the request is taken.
module phfe_out_reg import phfe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  phfe_rec_t rec_in,
    input  logic      m_ready,
    output logic      m_valid,
    output phfe_rec_t rec_out
);

    logic      valid_reg, valid_next;
    phfe_rec_t rec_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= rec_in;
        end
    end

    assign m_valid = valid_reg;
    assign rec_out = rec_reg;

endmodule

/* verif/tb_packet_header_field_extractor.sv */
// Testbench for the packet header field extractor: byte requests in, metadata records checked.
module tb_packet_header_field_extractor import phfe_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] ETYPE_ARP    = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
    localparam int          POS_SADDR    = 26;
    localparam int          POS_DADDR    = 30;
    localparam int          RANDOM_BYTES = 470;
    localparam int          MIN_PACKETS  = 6;
    localparam int          CALM_TAIL    = 300;

    typedef struct {
        logic [7:0]  data;
        logic        eop;
        logic [1:0]  dir;
        logic [31:0] ifc;
    } wire_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_pkt_byte = '0;
    logic        s_end_of_packet = 1'b0;
    logic [1:0]  s_pkt_direction = 2'd1;
    logic [31:0] s_iface_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_out_iface;
    logic [1:0]  m_out_direction;
    logic [15:0] m_pkt_length;
    logic [2:0]  m_ip_version;
    logic [7:0]  m_ip_protocol;
    logic [31:0] m_src_addr;
    logic [31:0] m_dst_addr;
    logic [15:0] m_src_port;
    logic [15:0] m_dst_port;

    wire_byte_t  pending[$];
    logic [7:0]  frame[$];
    phfe_rec_t   records_due[$];
    logic        in_took = 1'b0;
    logic        failed = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;

    // running header state of the packet in flight
    logic [15:0] pk_count = '0;
    logic [15:0] pk_etype = '0;
    logic [3:0]  pk_ihl = '0;
    logic [7:0]  pk_proto = '0;
    logic [31:0] pk_saddr = '0;
    logic [31:0] pk_daddr = '0;
    logic [15:0] pk_sport = '0;
    logic [15:0] pk_dport = '0;

    packet_header_field_extractor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pkt_byte      (s_pkt_byte),
        .s_end_of_packet (s_end_of_packet),
        .s_pkt_direction (s_pkt_direction),
        .s_iface_index   (s_iface_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_iface     (m_out_iface),
        .m_out_direction (m_out_direction),
        .m_pkt_length    (m_pkt_length),
        .m_ip_version    (m_ip_version),
        .m_ip_protocol   (m_ip_protocol),
        .m_src_addr      (m_src_addr),
        .m_dst_addr      (m_dst_addr),
        .m_src_port      (m_src_port),
        .m_dst_port      (m_dst_port)
    );

    always #6 aclk = ~aclk;

    function automatic int l4_start();
        if (pk_etype == ETYPE_IPV4) begin
            return (pk_ihl == 0) ? 0 : int'(ETH_HDR_LEN) + 4 * int'(pk_ihl);
        end
        if (pk_etype == ETYPE_IPV6) begin
            return int'(IPV6_L4_OFF);
        end
        return 0;
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic last,
                               input logic [1:0] dir, input logic [31:0] ifc);
        int        pos;
        int        off;
        phfe_rec_t rec;
        if (pk_count != COUNT_MAX) begin
            pos = int'(pk_count);
            if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO) begin
                pk_etype = {pk_etype[7:0], b};
            end
            if (pos >= ETH_HDR_LEN) begin
                if (pk_etype == ETYPE_IPV4) begin
                    if (pos == POS_IHL) pk_ihl = b[3:0];
                    if (pos == POS_V4_PROTO) pk_proto = b;
                    if (pos >= POS_SADDR && pos < POS_SADDR + 4) pk_saddr = {pk_saddr[23:0], b};
                    if (pos >= POS_DADDR && pos < POS_DADDR + 4) pk_daddr = {pk_daddr[23:0], b};
                end else if (pk_etype == ETYPE_IPV6) begin
                    if (pos == POS_V6_NEXT) pk_proto = b;
                end
                off = l4_start();
                if (off != 0 && pos >= off) begin
                    if (pos - off < 2) begin
                        pk_sport = {pk_sport[7:0], b};
                    end else if (pos - off < 4) begin
                        pk_dport = {pk_dport[7:0], b};
                    end
                end
            end
            pk_count++;
        end
        if (last) begin
            rec = '0;
            rec.iface = ifc;
            rec.direction = dir;
            rec.pkt_length = pk_count;
            rec.ip_version = VER_NONE;
            off = 0;
            if (pk_etype == ETYPE_IPV4 && pk_count >= IPV4_MIN_LEN) begin
                rec.ip_version = VER_IPV4;
                rec.ip_protocol = pk_proto;
                rec.src_addr = pk_saddr;
                rec.dst_addr = pk_daddr;
                off = l4_start();
            end else if (pk_etype == ETYPE_IPV6 && pk_count >= IPV6_MIN_LEN) begin
                rec.ip_version = VER_IPV6;
                rec.ip_protocol = pk_proto;
                off = l4_start();
            end
            if (off != 0 &&
                ((rec.ip_protocol == PROTO_TCP && int'(pk_count) >= off + int'(TCP_HDR_LEN)) ||
                 (rec.ip_protocol == PROTO_UDP && int'(pk_count) >= off + int'(UDP_HDR_LEN)))) begin
                rec.src_port = pk_sport;
                rec.dst_port = pk_dport;
            end
            records_due.push_back(rec);
            pk_count = '0;
            pk_etype = '0;
            pk_ihl = '0;
            pk_proto = '0;
            pk_saddr = '0;
            pk_daddr = '0;
            pk_sport = '0;
            pk_dport = '0;
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // random bytes with the header fields that steer the parse laid over them
    task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                               input logic [7:0] proto, input int len);
        frame.delete();
        for (int i = 0; i < len; i++) begin
            frame.push_back(8'($urandom));
        end
        if (len > POS_ETYPE_HI) frame[POS_ETYPE_HI] = etype[15:8];
        if (len > POS_ETYPE_LO) frame[POS_ETYPE_LO] = etype[7:0];
        if (etype == ETYPE_IPV4) begin
            if (len > POS_IHL) frame[POS_IHL] = {4'($urandom), ihl};
            if (len > POS_V4_PROTO) frame[POS_V4_PROTO] = proto;
        end else if (etype == ETYPE_IPV6) begin
            if (len > POS_V6_NEXT) frame[POS_V6_NEXT] = proto;
        end
    endtask

    task automatic queue_frame(input logic [1:0] dir, input logic [31:0] ifc);
        wire_byte_t wb;
        foreach (frame[i]) begin
            wb.data = frame[i];
            wb.eop = (i == frame.size() - 1);
            wb.dir = dir;
            wb.ifc = ifc;
            pending.push_back(wb);
        end
    endtask

    task automatic random_packet();
        int          kind;
        int          pick;
        int          off;
        int          need;
        int          len;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        kind = $urandom_range(0, 19);
        if (kind < 8) begin
            etype = ETYPE_IPV4;
        end else if (kind < 13) begin
            etype = ETYPE_IPV6;
        end else if (kind < 16) begin
            etype = 16'($urandom);
        end else begin
            etype = (kind[0] ? ETYPE_IPV4 : ETYPE_IPV6) ^ (16'd1 << $urandom_range(0, 15));
        end
        ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
        pick = $urandom_range(0, 9);
        proto = (pick < 4) ? PROTO_TCP : (pick < 8) ? PROTO_UDP : 8'($urandom);
        if (etype == ETYPE_IPV4) begin
            off = (ihl == 0) ? int'(IPV4_MIN_LEN) : int'(ETH_HDR_LEN) + 4 * int'(ihl);
        end else begin
            off = int'(IPV6_L4_OFF);
        end
        need = off + int'((proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN);
        if (need < IPV4_MIN_LEN) need = IPV4_MIN_LEN;
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, need);
        end else begin
            len = need + $urandom_range(0, 24);
        end
        build_frame(etype, ihl, proto, len);
        queue_frame(2'($urandom_range(1, 2)), $urandom);
    endtask

    // request driver
    always @(negedge aclk) begin : drive_requests
        wire_byte_t wb;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_took) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pending.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(0, 16);
                s_valid <= 1'b0;
            end else begin
                wb = pending.pop_front();
                s_valid <= 1'b1;
                s_pkt_byte <= wb.data;
                s_end_of_packet <= wb.eop;
                s_pkt_direction <= wb.dir;
                s_iface_index <= wb.ifc;
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on accepted requests, check records
    always @(posedge aclk) begin : watch_ports
        phfe_rec_t want;
        in_took = aresetn && s_valid && s_ready;
        if (in_took) begin
            absorb_byte(s_pkt_byte, s_end_of_packet, s_pkt_direction, s_iface_index);
        end
        if (aresetn && m_valid && m_ready) begin
            if (records_due.size() == 0) begin
                $error("record with none outstanding: iface 0x%0h length %0d",
                       m_out_iface, m_pkt_length);
                failed = 1'b1;
            end else begin
                want = records_due.pop_front();
                check_field("out_iface", want.iface, m_out_iface);
                check_field("out_direction", want.direction, m_out_direction);
                check_field("pkt_length", want.pkt_length, m_pkt_length);
                check_field("ip_version", want.ip_version, m_ip_version);
                check_field("ip_protocol", want.ip_protocol, m_ip_protocol);
                check_field("src_addr", want.src_addr, m_src_addr);
                check_field("dst_addr", want.dst_addr, m_dst_addr);
                check_field("src_port", want.src_port, m_src_port);
                check_field("dst_port", want.dst_port, m_dst_port);
            end
        end
    end

    initial begin
        int random_bytes;
        int random_pkts;

        // single-byte packets at the field extremes, then an all-ones non-IP frame
        build_frame(16'h0000, 4'd0, 8'd0, 1);
        frame[0] = 8'h00;
        queue_frame(2'd1, 32'h0000_0000);
        build_frame(16'h0000, 4'd0, 8'd0, 1);
        frame[0] = 8'hFF;
        queue_frame(2'd2, 32'hFFFF_FFFF);
        build_frame(16'hFFFF, 4'd0, 8'd0, 20);
        foreach (frame[i]) frame[i] = 8'hFF;
        queue_frame(2'd2, 32'hFFFF_FFFF);

        // IPv4: complete, truncated L4, truncated IP, bare IP header
        build_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 54);
        queue_frame(2'd1, $urandom);
        build_frame(ETYPE_IPV4, 4'd5, PROTO_UDP, 42);
        queue_frame(2'd2, $urandom);
        build_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 53);
        queue_frame(2'd1, $urandom);
        build_frame(ETYPE_IPV4, 4'd5, PROTO_UDP, 33);
        queue_frame(2'd2, $urandom);
        build_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 34);
        queue_frame(2'd1, $urandom);

        // IHL zero, IHL below five, largest IHL, other protocol
        build_frame(ETYPE_IPV4, 4'd0, PROTO_TCP, 60);
        queue_frame(2'd2, $urandom);
        build_frame(ETYPE_IPV4, 4'd1, PROTO_UDP, 40);
        queue_frame(2'd1, $urandom);
        build_frame(ETYPE_IPV4, 4'd15, PROTO_TCP, 114);
        queue_frame(2'd2, $urandom);
        build_frame(ETYPE_IPV4, 4'd5, PROTO_ICMP, 60);
        queue_frame(2'd1, $urandom);

        // IPv6
        build_frame(ETYPE_IPV6, 4'd0, PROTO_TCP, 74);
        queue_frame(2'd2, $urandom);
        build_frame(ETYPE_IPV6, 4'd0, PROTO_UDP, 62);
        queue_frame(2'd1, $urandom);
        build_frame(ETYPE_IPV6, 4'd0, PROTO_TCP, 53);
        queue_frame(2'd2, $urandom);
        build_frame(ETYPE_IPV6, 4'd0, PROTO_ICMPV6, 80);
        queue_frame(2'd1, $urandom);

        // non-IP, direction outside its range, then a complete IPv4 TCP frame
        build_frame(ETYPE_ARP, 4'd0, 8'd0, 60);
        queue_frame(2'd2, $urandom);
        build_frame(ETYPE_IPV4, 4'd5, PROTO_UDP, 42);
        queue_frame(2'd0, $urandom);
        build_frame(ETYPE_IPV4, 4'd5, PROTO_UDP, 42);
        queue_frame(2'd3, $urandom);
        build_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 54);
        queue_frame(2'd2, $urandom);

        random_bytes = 0;
        random_pkts = 0;
        while (random_bytes < RANDOM_BYTES || random_pkts < MIN_PACKETS) begin
            random_packet();
            random_bytes += frame.size();
            random_pkts++;
        end

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_valid) @(negedge aclk);
        while (records_due.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        if (records_due.size() != 0) begin
            $error("records outstanding at the end: %0d", records_due.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("tb_packet_header_field_extractor passed");
        end else begin
            $display("tb_packet_header_field_extractor failed");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("tb_packet_header_field_extractor failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/phfe_pkg.sv
design/phfe_parser.sv
design/phfe_out_reg.sv
design/packet_header_field_extractor.sv
verif/tb_packet_header_field_extractor.sv
